/* src/acsfc_pkg.sv */
// ----------------------------------------------------------------------------
// acsfc_pkg
// shared types and constants for the serial frame codec
// ----------------------------------------------------------------------------
package acsfc_pkg;

    localparam int          FRAME_LEN_DEF = 16;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          RUN_LEN       = 12;

    localparam logic [7:0]  HDR_BYTE      = 8'hAA;
    localparam logic [7:0]  CMD_TYPE      = 8'h03;
    localparam logic [7:0]  HB_TYPE       = 8'h02;
    localparam logic [7:0]  CMD_TAIL      = 8'h0B;
    localparam logic [7:0]  HB_SUM        = 8'hAC;

    typedef enum logic [1:0] {
        REQ_RX  = 2'd0,
        REQ_CMD = 2'd1,
        REQ_HB  = 2'd2,
        REQ_NOP = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        JOB_REPORT = 2'd0,
        JOB_CMD    = 2'd1,
        JOB_HB     = 2'd2
    } t_job_kind;

    // one queued job for the back end
    typedef struct packed {
        t_job_kind  kind;
        logic       changed;
        logic [2:0] mode_code;
        logic [2:0] action_code;
        logic [2:0] fan_level;
        logic       swing_on;
        logic       sleep_on;
        logic [7:0] set_temp;
        logic [7:0] current_temp;
        logic [7:0] cmd;
        logic [7:0] flags;
    } t_job;

    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_bk_state;

endpackage

/* src/acsfc_front.sv */
// ----------------------------------------------------------------------------
// acsfc_front
// accepts requests, assembles received frames, builds jobs
// ----------------------------------------------------------------------------
module acsfc_front #(
    parameter int FRAME_LEN = acsfc_pkg::FRAME_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_rx_byte,
    input  logic [2:0]        i_cmd_mode,
    input  logic [2:0]        i_cmd_fan,
    input  logic              i_cmd_swing,
    input  logic              i_cmd_sleep,
    input  logic [7:0]        i_cmd_set_temp,
    output logic              o_push,
    output acsfc_pkg::t_job   o_job
);
    import acsfc_pkg::*;

    localparam int PW = $clog2(FRAME_LEN + 1);
    localparam int IW = $clog2(FRAME_LEN);

    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_sum, n_sum;
    logic [2:0]    r_mnib, n_mnib;
    logic [7:0]    r_b1, r_b2, r_b3, r_b7, r_b11;
    logic [7:0]    r_p0, r_p1, r_p2, r_p3, r_p4;
    logic [IW-1:0] idx;
    logic          hunting, last_byte, good;
    logic [3:0]    hi, lo;
    logic [2:0]    fan_c;
    logic [7:0]    fan_nib;
    logic          chg;
    t_job          job;

    assign hunting   = (r_pos == '0) || (r_pos > PW'(FRAME_LEN));
    assign idx       = IW'(r_pos - PW'(1));
    assign last_byte = !hunting && (idx == IW'(FRAME_LEN - 1));
    assign good      = i_fire && (t_req'(i_req_type) == REQ_RX)
                    && last_byte && (r_sum == i_rx_byte);
    assign hi        = r_b1[7:4];
    assign lo        = r_b1[3:0];
    assign chg       = (r_p0 != r_b1) || (r_p1 != r_b2) || (r_p2 != r_b3)
                    || (r_p3 != r_b7) || (r_p4 != r_b11);

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_mnib = r_mnib;
        o_push = 1'b0;
        job    = '0;
        fan_c  = i_cmd_fan;
        if (fan_c == 3'd0) fan_c = 3'd1;
        if (fan_c > 3'd5) fan_c = 3'd5;
        fan_nib = 8'h80 + {1'b0, fan_c, 4'h0};
        if (i_fire) begin
            unique case (t_req'(i_req_type))
                REQ_RX: begin
                    if (hunting) begin
                        n_pos = (i_rx_byte == HDR_BYTE) ? PW'(1) : '0;
                        n_sum = (i_rx_byte == HDR_BYTE) ? HDR_BYTE : r_sum;
                    end else begin
                        if (idx < IW'(FRAME_LEN - 2)) n_sum = r_sum + i_rx_byte;
                        n_pos = last_byte ? '0 : r_pos + PW'(1);
                        if (good) begin
                            o_push           = 1'b1;
                            job.kind         = JOB_REPORT;
                            job.changed      = chg;
                            job.swing_on     = (r_b2[3:0] == 4'hC);
                            job.sleep_on     = r_b2[6];
                            job.set_temp     = r_b3;
                            job.current_temp = r_b7;
                            job.fan_level    = (hi >= 4'h9 && hi <= 4'hD)
                                             ? 3'(hi - 4'h8) : 3'd1;
                            if (hi == 4'h1) begin
                                job.mode_code   = 3'd0;
                                job.action_code = 3'd0;
                            end else begin
                                if (lo >= 4'd1 && lo <= 4'd4) begin
                                    job.mode_code   = lo[2:0];
                                    job.action_code = lo[2:0];
                                    n_mnib          = lo[2:0];
                                end else if (lo == 4'd0) begin
                                    job.mode_code   = 3'd5;
                                    job.action_code = 3'd1;
                                    n_mnib          = 3'd0;
                                end else begin
                                    job.mode_code   = 3'd1;
                                    job.action_code = 3'd1;
                                    n_mnib          = 3'd1;
                                end
                                if (r_b11[3:0] == 4'h0) job.action_code = 3'd5;
                            end
                        end
                    end
                end
                REQ_CMD: begin
                    job.kind = JOB_CMD;
                    if (i_cmd_mode >= 3'd1 && i_cmd_mode <= 3'd4) begin
                        n_mnib  = i_cmd_mode;
                        job.cmd = {5'd0, i_cmd_mode} + fan_nib;
                    end else if (i_cmd_mode == 3'd5) begin
                        n_mnib  = 3'd0;
                        job.cmd = fan_nib;
                    end else begin
                        job.cmd = {5'd0, r_mnib} + 8'h10;
                    end
                    job.flags       = (i_cmd_swing ? 8'h0C : 8'h00)
                                    | (i_cmd_sleep ? 8'h40 : 8'h00);
                    job.set_temp    = i_cmd_set_temp;
                    o_push          = (i_cmd_set_temp != 8'd0);
                end
                REQ_HB: begin
                    job.kind = JOB_HB;
                    o_push   = 1'b1;
                end
                REQ_NOP: ;
            endcase
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_mnib <= '0;
            r_p0 <= '0; r_p1 <= '0; r_p2 <= '0; r_p3 <= '0; r_p4 <= '0;
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_mnib <= n_mnib;
            if (good && chg) begin
                r_p0 <= r_b1; r_p1 <= r_b2; r_p2 <= r_b3; r_p3 <= r_b7; r_p4 <= r_b11;
            end
        end
    end

    // only the decoded bytes are kept
    always_ff @(posedge i_clk) begin
        if (i_fire && t_req'(i_req_type) == REQ_RX && !hunting) begin
            if (idx == IW'(1))  r_b1  <= i_rx_byte;
            if (idx == IW'(2))  r_b2  <= i_rx_byte;
            if (idx == IW'(3))  r_b3  <= i_rx_byte;
            if (idx == IW'(7))  r_b7  <= i_rx_byte;
            if (idx == IW'(11)) r_b11 <= i_rx_byte;
        end
    end

endmodule

/* src/acsfc_queue.sv */
// ----------------------------------------------------------------------------
// acsfc_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module acsfc_queue #(
    parameter int DEPTH = acsfc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acsfc_pkg::t_job i_job,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output acsfc_pkg::t_job o_job
);
    import acsfc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

/* src/acsfc_back.sv */
// ----------------------------------------------------------------------------
// acsfc_back
// plays out jobs: report in one beat, transmit runs byte by byte
// ----------------------------------------------------------------------------
module acsfc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  acsfc_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_kind,
    output logic [7:0]      o_tx_byte,
    output logic            o_last,
    output logic            o_changed,
    output logic [2:0]      o_mode_code,
    output logic [2:0]      o_action_code,
    output logic [2:0]      o_fan_level,
    output logic            o_swing_on,
    output logic            o_sleep_on,
    output logic [7:0]      o_set_temp,
    output logic [7:0]      o_current_temp
);
    import acsfc_pkg::*;

    t_bk_state  r_st, n_st;
    logic [3:0] r_k, n_k;
    logic [7:0] r_sum, n_sum;
    logic [7:0] byte_k;
    logic       take, is_last;

    assign take = o_valid && !i_stall;

    always_comb begin
        byte_k = 8'h00;
        if (i_job.kind == JOB_HB) begin
            unique case (r_k)
                4'd0:  byte_k = HDR_BYTE;
                4'd1:  byte_k = HB_TYPE;
                4'd11: byte_k = HB_SUM;
                default: byte_k = 8'h00;
            endcase
        end else begin
            unique case (r_k)
                4'd0:  byte_k = HDR_BYTE;
                4'd1:  byte_k = CMD_TYPE;
                4'd2:  byte_k = i_job.cmd;
                4'd3:  byte_k = i_job.flags;
                4'd4:  byte_k = i_job.set_temp;
                4'd8:  byte_k = CMD_TAIL;
                4'd11: byte_k = r_sum;
                default: byte_k = 8'h00;
            endcase
        end
    end

    always_comb begin
        n_st  = r_st;
        n_k   = r_k;
        n_sum = r_sum;
        o_pop = 1'b0;
        o_valid        = !i_empty;
        is_last        = (i_job.kind == JOB_REPORT) || (r_k == 4'(RUN_LEN - 1));
        o_kind         = (i_job.kind == JOB_REPORT);
        o_tx_byte      = o_kind ? 8'h00 : byte_k;
        o_last         = is_last;
        o_changed      = o_kind & i_job.changed;
        o_mode_code    = o_kind ? i_job.mode_code : 3'd0;
        o_action_code  = o_kind ? i_job.action_code : 3'd0;
        o_fan_level    = o_kind ? i_job.fan_level : 3'd0;
        o_swing_on     = o_kind & i_job.swing_on;
        o_sleep_on     = o_kind & i_job.sleep_on;
        o_set_temp     = o_kind ? i_job.set_temp : 8'd0;
        o_current_temp = o_kind ? i_job.current_temp : 8'd0;
        unique case (r_st)
            BK_IDLE: if (take) begin
                if (is_last) o_pop = 1'b1;
                else begin
                    n_st  = BK_RUN;
                    n_k   = 4'd1;
                    n_sum = byte_k;
                end
            end
            BK_RUN: if (take) begin
                if (is_last) begin
                    o_pop = 1'b1;
                    n_st  = BK_IDLE;
                    n_k   = 4'd0;
                end else begin
                    n_k   = r_k + 4'd1;
                    n_sum = r_sum + byte_k;
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= BK_IDLE;
            r_k   <= '0;
            r_sum <= '0;
        end else begin
            r_st  <= n_st;
            r_k   <= n_k;
            r_sum <= n_sum;
        end
    end

endmodule

/* src/ac_serial_frame_codec.sv */
// ----------------------------------------------------------------------------
// ac_serial_frame_codec
// byte-serial codec for an air-conditioner controller link
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  in      | input     | one request: received byte, command or heartbeat
//  out     | output    | one transmit byte or one decoded status report
//
//  a request is taken every cycle while the job queue has room
//  a good frame's report is queued when its checksum byte is taken and shown once it heads the queue
//  command and heartbeat runs are twelve bytes long and leave one byte per cycle while i_stall is low
//  the queue holds four jobs by default, and the input stalls whenever the queue is full
//  synchronous active-low reset clears frame hunt, checksum, mode and history
module ac_serial_frame_codec #(
    parameter int FRAME_LEN   = acsfc_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = acsfc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [2:0]  i_cmd_mode,
    input  logic [2:0]  i_cmd_fan,
    input  logic        i_cmd_swing,
    input  logic        i_cmd_sleep,
    input  logic [7:0]  i_cmd_set_temp,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic        o_changed,
    output logic [2:0]  o_mode_code,
    output logic [2:0]  o_action_code,
    output logic [2:0]  o_fan_level,
    output logic        o_swing_on,
    output logic        o_sleep_on,
    output logic [7:0]  o_set_temp,
    output logic [7:0]  o_current_temp
);
    import acsfc_pkg::*;

    logic fire, push, full, empty, pop;
    t_job f_job, q_job;

    // stall whenever full: simple and never drops a job
    assign o_stall = full;
    assign fire    = i_valid && !full;

    acsfc_front #(.FRAME_LEN(FRAME_LEN)) u_front (
        .i_clk, .i_rst_n, .i_fire(fire),
        .i_req_type, .i_rx_byte, .i_cmd_mode, .i_cmd_fan,
        .i_cmd_swing, .i_cmd_sleep, .i_cmd_set_temp,
        .o_push(push), .o_job(f_job)
    );

    acsfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_job(q_job)
    );

    acsfc_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(q_job), .o_pop(pop),
        .o_valid, .i_stall, .o_kind, .o_tx_byte, .o_last, .o_changed,
        .o_mode_code, .o_action_code, .o_fan_level, .o_swing_on, .o_sleep_on,
        .o_set_temp, .o_current_temp
    );

endmodule

/* src/acsfc_checker.sv */
// ----------------------------------------------------------------------------
// acsfc_checker
// port-level checks for the serial frame codec
// ----------------------------------------------------------------------------
module acsfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_kind,
    input logic       o_last,
    input logic [7:0] o_tx_byte,
    input logic       o_changed
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx_byte))
        else $error("stalled output changed");
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_last && o_tx_byte == 8'h00)
        else $error("report not marked last");
    a_tx_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> !o_changed)
        else $error("transmit byte carries status");
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid && !i_stall && o_last) && o_valid && !o_kind
        |-> o_tx_byte == 8'hAA)
        else $error("run does not open with header");
endmodule

bind ac_serial_frame_codec acsfc_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_kind, .o_last, .o_tx_byte, .o_changed
);

/* tb/tb_ac_serial_frame_codec.sv */
// ----------------------------------------------------------------------------
// tb_ac_serial_frame_codec
// self-checking testbench for the serial frame codec
// ----------------------------------------------------------------------------
// drives received bytes, command and heartbeat requests through the valid/stall
// input channel, predicts every transmit byte and status report in a model of
// the codec, and compares each output transaction field by field
// ----------------------------------------------------------------------------
module tb_ac_serial_frame_codec;
    timeunit 1ns;
    timeprecision 1ps;

    import acsfc_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    // one output transaction as the block presents it
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic       changed;
        logic [2:0] mode_code;
        logic [2:0] action_code;
        logic [2:0] fan_level;
        logic       swing_on;
        logic       sleep_on;
        logic [7:0] set_temp;
        logic [7:0] current_temp;
    } t_codec_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [2:0]  i_cmd_mode = '0;
    logic [2:0]  i_cmd_fan = '0;
    logic        i_cmd_swing = 1'b0;
    logic        i_cmd_sleep = 1'b0;
    logic [7:0]  i_cmd_set_temp = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic        o_changed;
    logic [2:0]  o_mode_code;
    logic [2:0]  o_action_code;
    logic [2:0]  o_fan_level;
    logic        o_swing_on;
    logic        o_sleep_on;
    logic [7:0]  o_set_temp;
    logic [7:0]  o_current_temp;

    always #6 i_clk = ~i_clk;

    ac_serial_frame_codec dut (.*);

    // model state
    logic [4:0]  frame_pos_m;
    logic [7:0]  frame_bytes_m [FRAME_LEN_DEF];
    logic [7:0]  checksum_m;
    logic [2:0]  mode_nib_m;
    logic [7:0]  published_m [5];

    t_codec_out  expected_q [$];
    int          mismatch_cnt = 0;
    int          idle_pct = 0;      // sender gap percentage
    int          stall_pct = 0;     // receiver stall percentage
    int          quiet_cycles = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic t_codec_out tx_item(logic [7:0] b, logic lst);
        t_codec_out r;
        r = '0;
        r.tx_byte = b;
        r.last = lst;
        return r;
    endfunction

    function automatic void queue_run(logic [7:0] run [RUN_LEN]);
        for (int k = 0; k < RUN_LEN; k++)
            expected_q.push_back(tx_item(run[k], k == RUN_LEN - 1));
    endfunction

    function automatic void decode_status();
        t_codec_out r;
        logic [3:0] hi, lo;
        logic       chg;
        r = '0;
        hi = frame_bytes_m[1][7:4];
        lo = frame_bytes_m[1][3:0];
        if (hi == 4'h1) begin
            r.mode_code = 3'd0;
            r.action_code = 3'd0;
        end else begin
            if (lo >= 1 && lo <= 4) begin
                r.mode_code = lo[2:0];
                r.action_code = lo[2:0];
                mode_nib_m = lo[2:0];
            end else if (lo == 0) begin
                r.mode_code = 3'd5;
                r.action_code = 3'd1;
                mode_nib_m = 3'd0;
            end else begin
                r.mode_code = 3'd1;
                r.action_code = 3'd1;
                mode_nib_m = 3'd1;
            end
            if (frame_bytes_m[11][3:0] == 4'h0) r.action_code = 3'd5;
        end
        r.fan_level = (hi >= 4'h9 && hi <= 4'hD) ? 3'(hi - 4'h9 + 1) : 3'd1;
        chg = published_m[0] != frame_bytes_m[1] || published_m[1] != frame_bytes_m[2]
           || published_m[2] != frame_bytes_m[3] || published_m[3] != frame_bytes_m[7]
           || published_m[4] != frame_bytes_m[11];
        if (chg) begin
            published_m[0] = frame_bytes_m[1];
            published_m[1] = frame_bytes_m[2];
            published_m[2] = frame_bytes_m[3];
            published_m[3] = frame_bytes_m[7];
            published_m[4] = frame_bytes_m[11];
        end
        r.kind = 1'b1;
        r.last = 1'b1;
        r.changed = chg;
        r.swing_on = frame_bytes_m[2][3:0] == 4'hC;
        r.sleep_on = frame_bytes_m[2][6];
        r.set_temp = frame_bytes_m[3];
        r.current_temp = frame_bytes_m[7];
        expected_q.push_back(r);
    endfunction

    function automatic void predict_codec(t_req req, logic [7:0] rxb, logic [2:0] md,
                                          logic [2:0] fan, logic sw, logic slp,
                                          logic [7:0] tgt);
        logic [7:0] run [RUN_LEN];
        logic [7:0] fan_nib, cmd, flags;
        logic [3:0] idx;
        logic [2:0] f;
        case (req)
            REQ_RX: begin
                if (frame_pos_m == 0 || frame_pos_m > FRAME_LEN_DEF) begin
                    if (rxb == HDR_BYTE) begin
                        frame_pos_m = 5'd1;
                        checksum_m = HDR_BYTE;
                    end else begin
                        frame_pos_m = 5'd0;
                    end
                end else begin
                    idx = 4'(frame_pos_m - 1);
                    frame_bytes_m[idx] = rxb;
                    if (idx < FRAME_LEN_DEF - 2) checksum_m += rxb;
                    if (idx < FRAME_LEN_DEF - 1) begin
                        frame_pos_m++;
                    end else begin
                        frame_pos_m = 5'd0;
                        if (checksum_m == frame_bytes_m[FRAME_LEN_DEF - 1]) decode_status();
                    end
                end
            end
            REQ_CMD: begin
                f = (fan == 0) ? 3'd1 : (fan > 5) ? 3'd5 : fan;
                if (md >= 1 && md <= 4) begin
                    mode_nib_m = md;
                    fan_nib = 8'h80 + {1'b0, f, 4'h0};
                end else if (md == 5) begin
                    mode_nib_m = 3'd0;
                    fan_nib = 8'h80 + {1'b0, f, 4'h0};
                end else begin
                    fan_nib = 8'h10;
                end
                if (tgt != 0) begin
                    cmd = fan_nib + mode_nib_m;
                    flags = (sw ? 8'h0C : 8'h00) | (slp ? 8'h40 : 8'h00);
                    run = '{default: 8'h00};
                    run[0] = HDR_BYTE;
                    run[1] = CMD_TYPE;
                    run[2] = cmd;
                    run[3] = flags;
                    run[4] = tgt;
                    run[8] = CMD_TAIL;
                    run[11] = HDR_BYTE + CMD_TYPE + cmd + flags + tgt + CMD_TAIL;
                    queue_run(run);
                end
            end
            REQ_HB: begin
                run = '{default: 8'h00};
                run[0] = HDR_BYTE;
                run[1] = HB_TYPE;
                run[11] = HB_SUM;
                queue_run(run);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender side: one transaction per call
    // ------------------------------------------------------------------
    task automatic send_request(t_req req, logic [7:0] rxb = 8'h00, logic [2:0] md = 3'd0,
                                logic [2:0] fan = 3'd1, logic sw = 1'b0,
                                logic slp = 1'b0, logic [7:0] tgt = 8'h00);
        // random gap before the transaction, valid stays low
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_rx_byte <= rxb;
        i_cmd_mode <= md;
        i_cmd_fan <= fan;
        i_cmd_swing <= sw;
        i_cmd_sleep <= slp;
        i_cmd_set_temp <= tgt;
        do @(posedge i_clk); while (o_stall);
        // accepted at this edge
        predict_codec(req, rxb, md, fan, sw, slp, tgt);
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
    endtask

    task automatic send_rx(logic [7:0] b);
        send_request(REQ_RX, b);
    endtask

    // header plus 16 bytes; good checksum unless corrupt is set
    task automatic send_frame(logic [7:0] body [FRAME_LEN_DEF], bit corrupt);
        logic [7:0] s;
        s = HDR_BYTE;
        for (int k = 0; k < FRAME_LEN_DEF - 2; k++) s += body[k];
        body[FRAME_LEN_DEF - 1] = corrupt ? s ^ 8'(1 << $urandom_range(7)) : s;
        send_rx(HDR_BYTE);
        for (int k = 0; k < FRAME_LEN_DEF; k++) send_rx(body[k]);
    endtask

    function automatic void random_body(output logic [7:0] body [FRAME_LEN_DEF]);
        for (int k = 0; k < FRAME_LEN_DEF; k++) body[k] = 8'($urandom);
        // keep decoded fields in interesting ranges most of the time
        if ($urandom_range(3) != 0)
            body[1] = {4'($urandom_range(9, 13)), 4'($urandom_range(0, 6))};
        if ($urandom_range(4) == 0) body[1][7:4] = 4'h1;
        if ($urandom_range(2) == 0) body[11][3:0] = 4'h0;
        if ($urandom_range(2) == 0) body[2] = {1'b0, 1'($urandom), 2'b00, 4'hC};
    endfunction

    // sender holds off until the output side has drained
    task automatic wait_drained();
        go_quiet();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stall and the checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_codec_out got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_kind, o_tx_byte, o_last, o_changed, o_mode_code, o_action_code,
                    o_fan_level, o_swing_on, o_sleep_on, o_set_temp, o_current_temp};
            if (expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected output transaction %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // watchdog over cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_heartbeat();
        send_request(REQ_HB);
        send_request(REQ_NOP, 8'hFF, 3'd7, 3'd7, 1'b1, 1'b1, 8'hFF);
    endtask

    task automatic test_commands();
        send_request(REQ_CMD, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 8'h01);  // off, fan not used in this mode
        send_request(REQ_CMD, 8'h00, 3'd1, 3'd1, 1'b1, 1'b0, 8'hFF);
        send_request(REQ_CMD, 8'h00, 3'd4, 3'd7, 1'b0, 1'b1, 8'h18);  // fan high clamp
        send_request(REQ_CMD, 8'h00, 3'd5, 3'd5, 1'b1, 1'b1, 8'h00);  // suppressed
        send_request(REQ_CMD, 8'h00, 3'd7, 3'd3, 1'b0, 1'b0, 8'h16);  // out-of-range mode
        send_request(REQ_CMD, 8'h00, 3'd2, 3'd6, 1'b1, 1'b0, 8'h80);
    endtask

    task automatic test_frames();
        logic [7:0] body [FRAME_LEN_DEF];
        body = '{default: 8'h00};
        send_rx(8'h55);                       // noise while hunting
        body[1] = 8'h93;
        body[2] = 8'h4C;
        body[3] = 8'hAA;                      // header value inside a frame
        body[7] = 8'hFF;
        body[11] = 8'h01;
        send_frame(body, 1'b0);
        send_frame(body, 1'b0);               // same content: not changed
        body[1] = 8'h10;                      // standby
        send_frame(body, 1'b0);
        body[1] = 8'hE7;                      // unknown fan and mode
        body[11] = 8'hF0;                     // idle
        send_frame(body, 1'b1);               // bad checksum
        send_request(REQ_HB);                 // heartbeat between frames
        send_rx(HDR_BYTE);
        for (int k = 0; k < 3; k++) send_rx(8'(k));
        send_request(REQ_CMD, 8'h00, 3'd3, 3'd2, 1'b0, 1'b0, 8'h20);
        for (int k = 3; k < FRAME_LEN_DEF; k++) send_rx(8'h00);
        send_frame(body, 1'b0);
        body[1] = 8'hD0;                      // smart cool
        send_frame(body, 1'b0);
    endtask

    task automatic test_random(int n_items);
        logic [7:0] body [FRAME_LEN_DEF];
        int sent;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    random_body(body);
                    send_frame(body, $urandom_range(5) == 0);
                    sent += 17;
                end
                5, 6: begin
                    send_request(REQ_CMD, 8'($urandom), 3'($urandom), 3'($urandom),
                                 1'($urandom), 1'($urandom),
                                 ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
                    sent++;
                end
                7: begin
                    send_request(REQ_HB);
                    sent++;
                end
                8: begin
                    send_rx(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
                    sent++;
                end
                default: begin
                    send_request(t_req'($urandom_range(3)), 8'($urandom), 3'($urandom),
                                 3'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        frame_pos_m = '0;
        checksum_m = '0;
        mode_nib_m = '0;
        frame_bytes_m = '{default: 8'h00};
        published_m = '{default: 8'h00};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_heartbeat();
        test_commands();
        test_frames();
        wait_drained();

        // random traffic over phases of sender idle and receiver stall
        idle_pct = 0;  stall_pct = 0;  test_random(5);
        idle_pct = 66; stall_pct = 0;  test_random(5);
        wait_drained();
        idle_pct = 0;  stall_pct = 66; test_random(5);
        idle_pct = 26; stall_pct = 26; test_random(5);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
